// ===== hw/rtl/scfp_pkg.sv =====
// scfp_pkg: types, codes and constants shared by the frame parser modules
// no dependencies; every other file refers to it by scoped names
package scfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned FT_W       = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // frame layout
  localparam int unsigned POS_LEN_HIGH   = 2;
  localparam int unsigned POS_LEN_LOW    = 3;
  localparam int unsigned POS_SEQ_HIGH   = 4;
  localparam int unsigned POS_SEQ_LOW    = 5;
  localparam int unsigned POS_CMD        = 6;
  localparam int unsigned FRAME_OVERHEAD = 6;
  localparam int unsigned RUNT_TOTAL     = 9;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd2;

  localparam logic [BYTE_W-1:0] HEAD_FIRST_RESET  = 8'h5A;
  localparam logic [BYTE_W-1:0] HEAD_SECOND_RESET = 8'hA5;

  localparam logic [BYTE_W-1:0] CMD_FORWARD = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_SHELL   = 8'h02;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    IN_FRAME
  } hunt_t;

  typedef enum logic [2:0] {
    KIND_LEN_HIGH,
    KIND_PLAIN,
    KIND_SEQ_HIGH,
    KIND_SEQ_LOW,
    KIND_CMD,
    KIND_SUM_HIGH,
    KIND_SUM_LOW
  } kind_t;

  typedef enum logic [1:0] {
    CLOSE_NONE,
    CLOSE_DONE,
    CLOSE_RUNT,
    CLOSE_OVERFLOW
  } close_t;

  typedef enum logic [2:0] {
    VERDICT_NONE     = 3'd0,
    VERDICT_FORWARD  = 3'd1,
    VERDICT_SHELL    = 3'd2,
    VERDICT_UNKNOWN  = 3'd3,
    VERDICT_SUM_FAIL = 3'd4,
    VERDICT_OVERFLOW = 3'd5,
    VERDICT_RUNT     = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_first;
    logic [BYTE_W-1:0] head_second;
    logic              check_enable;
  } cfg_t;

  // one classified body byte on its way from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    kind_t              kind;
    close_t             close;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  body_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
    verdict_t           verdict;
    logic [BYTE_W-1:0]  command;
    logic [SEQ_W-1:0]   sequence_res;
    logic               sum_ok;
    logic [SUM_W-1:0]   computed_sum;
  } result_t;

endpackage

// ===== hw/rtl/scfp_front.sv =====
// scfp_front: header hunt and frame position tracking, classifies body bytes
// depends on scfp_pkg
module scfp_front #(
  parameter int MAX_PACKET = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [scfp_pkg::BYTE_W-1:0] rx_byte,
  input  scfp_pkg::cfg_t              cfg,
  output logic                        push,
  output scfp_pkg::item_t             item
);

  localparam int PW = $clog2(MAX_PACKET + 1);
  localparam int CW = ((PW > scfp_pkg::FT_W) ? PW : scfp_pkg::FT_W) + 1;
  localparam int XW = PW + scfp_pkg::INDEX_W;

  scfp_pkg::hunt_t                 phase, phase_next;
  logic [PW-1:0]                   position, position_next;
  logic [scfp_pkg::FT_W-1:0]       frame_total, frame_total_next;
  logic [scfp_pkg::BYTE_W-1:0]     length_high, length_high_next;

  logic [CW-1:0] pos_w, tot_w;
  logic [XW-1:0] pos_x;
  logic          is_sum, done, overflow;

  assign pos_w    = CW'(position);
  assign tot_w    = CW'(frame_total);
  assign pos_x    = XW'(position);
  assign is_sum   = (frame_total != '0) && (pos_w + CW'(2) >= tot_w);
  assign done     = (frame_total != '0) && (pos_w + CW'(1) == tot_w);
  assign overflow = !done && (pos_w + CW'(1) >= CW'(MAX_PACKET));

  // next state
  always_comb begin
    phase_next       = phase;
    position_next    = position;
    frame_total_next = frame_total;
    length_high_next = length_high;
    if (fire) begin
      case (phase)
        scfp_pkg::HUNT_FIRST: begin
          if (rx_byte == cfg.head_first) phase_next = scfp_pkg::HUNT_SECOND;
        end
        scfp_pkg::HUNT_SECOND: begin
          if (rx_byte == cfg.head_second) begin
            phase_next       = scfp_pkg::IN_FRAME;
            position_next    = PW'(scfp_pkg::POS_LEN_HIGH);
            frame_total_next = '0;
          end else if (rx_byte != cfg.head_first) begin
            phase_next = scfp_pkg::HUNT_FIRST;
          end
        end
        scfp_pkg::IN_FRAME: begin
          position_next = PW'(pos_w + CW'(1));
          if (!is_sum) begin
            if (position == PW'(scfp_pkg::POS_LEN_HIGH)) begin
              length_high_next = rx_byte;
            end else if (position == PW'(scfp_pkg::POS_LEN_LOW)) begin
              frame_total_next = scfp_pkg::FT_W'({length_high, rx_byte})
                               + scfp_pkg::FT_W'(scfp_pkg::FRAME_OVERHEAD);
            end
          end
          if (done || overflow) begin
            phase_next       = scfp_pkg::HUNT_FIRST;
            position_next    = '0;
            frame_total_next = '0;
          end
        end
        default: begin
          phase_next = scfp_pkg::HUNT_FIRST;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    push       = fire && (phase == scfp_pkg::IN_FRAME);
    item.data  = rx_byte;
    item.index = pos_x[scfp_pkg::INDEX_W-1:0];
    if (is_sum) begin
      item.kind = (pos_w + CW'(2) == tot_w) ? scfp_pkg::KIND_SUM_HIGH
                                            : scfp_pkg::KIND_SUM_LOW;
    end else begin
      case (position)
        PW'(scfp_pkg::POS_LEN_HIGH): item.kind = scfp_pkg::KIND_LEN_HIGH;
        PW'(scfp_pkg::POS_SEQ_HIGH): item.kind = scfp_pkg::KIND_SEQ_HIGH;
        PW'(scfp_pkg::POS_SEQ_LOW):  item.kind = scfp_pkg::KIND_SEQ_LOW;
        PW'(scfp_pkg::POS_CMD):      item.kind = scfp_pkg::KIND_CMD;
        default:                     item.kind = scfp_pkg::KIND_PLAIN;
      endcase
    end
    if (done) begin
      item.close = (frame_total < scfp_pkg::FT_W'(scfp_pkg::RUNT_TOTAL))
                 ? scfp_pkg::CLOSE_RUNT : scfp_pkg::CLOSE_DONE;
    end else if (overflow) begin
      item.close = scfp_pkg::CLOSE_OVERFLOW;
    end else begin
      item.close = scfp_pkg::CLOSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= scfp_pkg::HUNT_FIRST;
      position    <= '0;
      frame_total <= '0;
      length_high <= '0;
    end else begin
      phase       <= phase_next;
      position    <= position_next;
      frame_total <= frame_total_next;
      length_high <= length_high_next;
    end
  end

endmodule

// ===== hw/rtl/scfp_queue.sv =====
// scfp_queue: short fifo of classified items between front and back
// depends on scfp_pkg
module scfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scfp_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output scfp_pkg::item_t head_item
);

  scfp_pkg::item_t                entries [scfp_pkg::QUEUE_DEPTH];
  logic [scfp_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [scfp_pkg::QCNT_W-1:0]    count, count_next;

  function automatic logic [scfp_pkg::QPTR_W-1:0] bump(
    input logic [scfp_pkg::QPTR_W-1:0] p
  );
    return (p == scfp_pkg::QPTR_W'(scfp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == scfp_pkg::QCNT_W'(scfp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/scfp_back.sv =====
// scfp_back: running sum, field capture, verdict and output register
// depends on scfp_pkg
module scfp_back (
  input  logic              clk,
  input  logic              rst,
  input  scfp_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  scfp_pkg::item_t   head_item,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output scfp_pkg::result_t res
);

  logic [scfp_pkg::SUM_W-1:0]  running_sum, sum_base, sum_new;
  logic [scfp_pkg::SEQ_W-1:0]  sequence_reg, seq_base, seq_new;
  logic [scfp_pkg::BYTE_W-1:0] command_reg, cmd_base, cmd_new;
  logic [scfp_pkg::BYTE_W-1:0] sum_high, sum_high_new;
  logic                        match, out_valid_next;
  scfp_pkg::result_t           res_next;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    if (head_item.kind == scfp_pkg::KIND_LEN_HIGH) begin
      // first body byte: sum restarts from the two header bytes
      sum_base = scfp_pkg::SUM_W'(cfg.head_first) + scfp_pkg::SUM_W'(cfg.head_second);
      seq_base = '0;
      cmd_base = '0;
    end else begin
      sum_base = running_sum;
      seq_base = sequence_reg;
      cmd_base = command_reg;
    end
    sum_new      = sum_base + scfp_pkg::SUM_W'(head_item.data);
    seq_new      = seq_base;
    cmd_new      = cmd_base;
    sum_high_new = sum_high;
    case (head_item.kind)
      scfp_pkg::KIND_SEQ_HIGH: seq_new = {head_item.data, seq_base[scfp_pkg::BYTE_W-1:0]};
      scfp_pkg::KIND_SEQ_LOW:  seq_new = {seq_base[scfp_pkg::SEQ_W-1:scfp_pkg::BYTE_W],
                                          head_item.data};
      scfp_pkg::KIND_CMD:      cmd_new = head_item.data;
      scfp_pkg::KIND_SUM_HIGH: begin
        sum_new      = sum_base;
        sum_high_new = head_item.data;
      end
      scfp_pkg::KIND_SUM_LOW:  sum_new = sum_base;
      default: ;
    endcase
  end

  assign match = ({sum_high, head_item.data} == sum_new);

  always_comb begin
    res_next.body_byte    = head_item.data;
    res_next.byte_index   = head_item.index;
    res_next.computed_sum = sum_new;
    res_next.last         = 1'b1;
    res_next.command      = cmd_new;
    res_next.sequence_res = seq_new;
    res_next.sum_ok       = 1'b0;
    res_next.verdict      = scfp_pkg::VERDICT_NONE;
    case (head_item.close)
      scfp_pkg::CLOSE_DONE: begin
        res_next.sum_ok = match;
        if (cfg.check_enable && !match) res_next.verdict = scfp_pkg::VERDICT_SUM_FAIL;
        else if (cmd_new == scfp_pkg::CMD_FORWARD) res_next.verdict = scfp_pkg::VERDICT_FORWARD;
        else if (cmd_new == scfp_pkg::CMD_SHELL) res_next.verdict = scfp_pkg::VERDICT_SHELL;
        else res_next.verdict = scfp_pkg::VERDICT_UNKNOWN;
      end
      scfp_pkg::CLOSE_RUNT: begin
        res_next.sum_ok       = match;
        res_next.verdict      = scfp_pkg::VERDICT_RUNT;
        res_next.command      = '0;
        res_next.sequence_res = '0;
      end
      scfp_pkg::CLOSE_OVERFLOW: begin
        res_next.verdict = scfp_pkg::VERDICT_OVERFLOW;
      end
      default: begin
        res_next.last         = 1'b0;
        res_next.command      = '0;
        res_next.sequence_res = '0;
      end
    endcase
  end

  assign out_valid_next = pop ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      running_sum  <= sum_new;
      sequence_reg <= seq_new;
      command_reg  <= cmd_new;
      sum_high     <= sum_high_new;
      res          <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
  end

endmodule

// ===== hw/rtl/sum_checked_frame_parser.sv =====
// sum_checked_frame_parser: length-prefixed frame parser with 16-bit byte sum
// an accepted body byte is written into the queue, then into the output register that shows it as a result
// one byte per cycle while the queue is not full, set by the hunt/position loop in the front
// header and hunted bytes give no result; a stalled output backs up a two-item queue
// reset (rst, synchronous, active high) restores header bytes 0x5a/0xa5, disables checking
// and returns to hunting with the queue and output register empty
module sum_checked_frame_parser #(
  parameter int MAX_PACKET = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data,
  // received byte channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      body_byte,
  output logic [11:0]                     byte_index,
  output logic                            last,
  output logic [2:0]                      verdict,
  output logic [7:0]                      command,
  output logic [15:0]                     sequence_res,
  output logic                            sum_ok,
  output logic [15:0]                     computed_sum
);

  scfp_pkg::cfg_t    cfg;
  scfp_pkg::item_t   push_item, head_item;
  scfp_pkg::result_t res;
  logic              in_fire, push, pop, q_full, head_valid;

  // configuration registers: write only while the parser is idle, the block does not check
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_first   <= scfp_pkg::HEAD_FIRST_RESET;
      cfg.head_second  <= scfp_pkg::HEAD_SECOND_RESET;
      cfg.check_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        scfp_pkg::REG_HEAD_FIRST:   cfg.head_first   <= cfg_data;
        scfp_pkg::REG_HEAD_SECOND:  cfg.head_second  <= cfg_data;
        scfp_pkg::REG_CHECK_ENABLE: cfg.check_enable <= cfg_data[0];
        default: ; // index beyond the list is dropped
      endcase
    end
  end

  // input is held off only when the queue is full, so the front runs freely
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  // front: hunts the header, tracks position and length, tags each body item
  scfp_front #(
    .MAX_PACKET (MAX_PACKET)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .push    (push),
    .item    (push_item)
  );

  // queue lets the front keep taking bytes while a result waits downstream
  scfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: sum, sequence/command capture, verdict, registered result
  scfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .res        (res)
  );

  assign body_byte    = res.body_byte;
  assign byte_index   = res.byte_index;
  assign last         = res.last;
  assign verdict      = res.verdict;
  assign command      = res.command;
  assign sequence_res = res.sequence_res;
  assign sum_ok       = res.sum_ok;
  assign computed_sum = res.computed_sum;

endmodule

// ===== hw/rtl/scfp_checker.sv =====
// scfp_checker: port-level assertions on the frame parser result channel
// depends on scfp_pkg; bound to sum_checked_frame_parser below
module scfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  body_byte,
  input logic [11:0] byte_index,
  input logic        last,
  input logic [2:0]  verdict,
  input logic [7:0]  command,
  input logic [15:0] sequence_res,
  input logic        sum_ok,
  input logic [15:0] computed_sum
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(body_byte) && $stable(byte_index)
      && $stable(last) && $stable(verdict) && $stable(command)
      && $stable(sequence_res) && $stable(sum_ok) && $stable(computed_sum))
    else $error("stalled result changed");

  // mid-frame items carry no frame summary
  a_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> verdict == scfp_pkg::VERDICT_NONE && !sum_ok
      && command == 8'd0 && sequence_res == 16'd0)
    else $error("mid-frame item carries verdict fields");

  // runt frames report no command or sequence
  a_runt: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == scfp_pkg::VERDICT_RUNT |-> last && command == 8'd0
      && sequence_res == 16'd0)
    else $error("runt verdict with command fields");

  // an overflow abort is a last item without a sum match
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == scfp_pkg::VERDICT_OVERFLOW |-> last && !sum_ok)
    else $error("overflow verdict malformed");

  // a final item always has a verdict
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> verdict != scfp_pkg::VERDICT_NONE)
    else $error("last item without verdict");

endmodule

bind sum_checked_frame_parser scfp_checker u_checker (.*);

// ===== bench/sum_checked_frame_parser_test.sv =====
// sum_checked_frame_parser_test: self-checking bench for the frame parser, with its own
// model of header hunting, length, sum and verdict; depends on scfp_pkg and the parser rtl
`timescale 1ns / 100ps

module sum_checked_frame_parser_test;

  localparam int MAX_PACKET  = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 8;       // output register plus two-entry queue, with margin
  localparam int REPORT_MAX  = 40;      // keep the log short when things go badly wrong

  // index past the end of the register list, writes there must be ignored
  localparam logic [scfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_write = 1'b0;
  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  body_byte;
  logic [11:0] byte_index;
  logic        last;
  logic [2:0]  verdict;
  logic [7:0]  command;
  logic [15:0] sequence_res;
  logic        sum_ok;
  logic [15:0] computed_sum;

  sum_checked_frame_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .body_byte(body_byte),
    .byte_index(byte_index),
    .last(last),
    .verdict(verdict),
    .command(command),
    .sequence_res(sequence_res),
    .sum_ok(sum_ok),
    .computed_sum(computed_sum)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and body results the parser still owes us
  logic [7:0]        rx_pending[$];
  scfp_pkg::result_t expected_body[$];
  int                queued_count = 0;
  int                mismatches   = 0;
  int                cycle_count  = 0;

  // idling percentages, changed by the sequencer between phases
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // parser model: configuration copy
  logic [7:0] cfg_first;
  logic [7:0] cfg_second;
  logic       cfg_check;

  // parser model: frame state
  scfp_pkg::hunt_t hunt_state;
  logic [12:0]     frame_pos;
  logic [16:0]     frame_total;   // zero while the length field is still unknown
  logic [7:0]      len_high;
  logic [15:0]     byte_sum;
  logic [15:0]     seq_num;
  logic [7:0]      cmd_byte;
  logic [7:0]      sum_high;

  scfp_pkg::result_t got_r;
  scfp_pkg::result_t want_r;

  // back to hunting for the first header byte
  function automatic void restart_hunt();
    hunt_state  = scfp_pkg::HUNT_FIRST;
    frame_pos   = '0;
    frame_total = '0;
    byte_sum    = '0;
  endfunction

  // model of one accepted byte; body bytes push one expected result
  function automatic void parse_rx_byte(input logic [7:0] b);
    scfp_pkg::result_t r;
    int                pos;
    bit                trailer;
    logic [15:0]       rx_sum;
    r = '0;
    if (hunt_state == scfp_pkg::IN_FRAME) begin
      pos = frame_pos;
      // the two trailing bytes carry the sum and are left out of it
      trailer = (frame_total != 0) && (pos + 2 >= frame_total);
      if (trailer) begin
        if (pos + 2 == frame_total) sum_high = b;
      end else begin
        byte_sum = byte_sum + 16'(b);
        case (pos)
          scfp_pkg::POS_LEN_HIGH: len_high = b;
          scfp_pkg::POS_LEN_LOW:  frame_total = 17'({len_high, b})
                                              + 17'(scfp_pkg::FRAME_OVERHEAD);
          scfp_pkg::POS_SEQ_HIGH: seq_num = {b, 8'h00};
          scfp_pkg::POS_SEQ_LOW:  seq_num[7:0] = b;
          scfp_pkg::POS_CMD:      cmd_byte = b;
          default: ;
        endcase
      end
      frame_pos = 13'(pos + 1);
      r.body_byte    = b;
      r.byte_index   = pos[11:0];
      r.computed_sum = byte_sum;
      if (frame_total != 0 && frame_pos == frame_total) begin
        rx_sum   = {sum_high, b};
        r.sum_ok = (rx_sum == byte_sum);
        r.last   = 1'b1;
        if (frame_total < scfp_pkg::RUNT_TOTAL) begin
          // length too short for sequence and command, those stay zero
          r.verdict = scfp_pkg::VERDICT_RUNT;
        end else begin
          r.command      = cmd_byte;
          r.sequence_res = seq_num;
          // a bad sum outranks the command when checking is on
          if (cfg_check && !r.sum_ok) r.verdict = scfp_pkg::VERDICT_SUM_FAIL;
          else if (cmd_byte == scfp_pkg::CMD_FORWARD) r.verdict = scfp_pkg::VERDICT_FORWARD;
          else if (cmd_byte == scfp_pkg::CMD_SHELL) r.verdict = scfp_pkg::VERDICT_SHELL;
          else r.verdict = scfp_pkg::VERDICT_UNKNOWN;
        end
      end else if (frame_pos >= MAX_PACKET) begin
        // frame ran into the size limit before completing
        r.last         = 1'b1;
        r.verdict      = scfp_pkg::VERDICT_OVERFLOW;
        r.command      = cmd_byte;
        r.sequence_res = seq_num;
      end
      expected_body.push_back(r);
      if (r.last) restart_hunt();
    end else if (hunt_state == scfp_pkg::HUNT_SECOND) begin
      if (b == cfg_second) begin
        hunt_state  = scfp_pkg::IN_FRAME;
        frame_pos   = 13'd2;
        byte_sum    = byte_sum + 16'(b);
        frame_total = '0;
        seq_num     = '0;
        cmd_byte    = '0;
      end else if (b == cfg_first) begin
        // a wrong second byte may itself start a new header
        frame_pos = 13'd1;
        byte_sum  = 16'(b);
      end else begin
        restart_hunt();
      end
    end else begin
      if (b == cfg_first) begin
        hunt_state = scfp_pkg::HUNT_SECOND;
        frame_pos  = 13'd1;
        byte_sum   = 16'(b);
      end else begin
        restart_hunt();
      end
    end
  endfunction

  // a byte that is neither header byte under the current settings
  function automatic logic [7:0] idle_byte();
    logic [7:0] b;
    b = cfg_first + 8'd1;
    if (b == cfg_second) b = cfg_first + 8'd2;
    return b;
  endfunction

  function automatic int field_differs(input string name, input logic [15:0] want_v,
                                       input logic [15:0] got_v);
    if (got_v === want_v) return 0;
    if (mismatches < REPORT_MAX) $error("%s: expected %0h, got %0h", name, want_v, got_v);
    return 1;
  endfunction

  // sender: presents queued bytes, holds a stalled byte, models each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_rx_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, each accepted result checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_r = '{body_byte, byte_index, last, scfp_pkg::verdict_t'(verdict), command,
                  sequence_res, sum_ok, computed_sum};
        if (expected_body.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $error("result with nothing expected: body_byte %0h byte_index %0d",
                   body_byte, byte_index);
          mismatches++;
        end else begin
          want_r = expected_body.pop_front();
          mismatches += field_differs("body_byte", want_r.body_byte, got_r.body_byte);
          mismatches += field_differs("byte_index", want_r.byte_index, got_r.byte_index);
          mismatches += field_differs("last", want_r.last, got_r.last);
          mismatches += field_differs("verdict", want_r.verdict, got_r.verdict);
          mismatches += field_differs("command", want_r.command, got_r.command);
          mismatches += field_differs("sequence_res", want_r.sequence_res, got_r.sequence_res);
          mismatches += field_differs("sum_ok", want_r.sum_ok, got_r.sum_ok);
          mismatches += field_differs("computed_sum", want_r.computed_sum, got_r.computed_sum);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one frame: header, length, then len body bytes (sequence, command, data), then the sum
  // cut >= 0 sends only that many bytes; fill >= 0 replaces random data bytes
  task automatic queue_frame(input int len, input logic [7:0] cmd, input logic [15:0] seq,
                             input bit bad_sum, input int cut, input int fill);
    logic [7:0]  frame_bytes[$];
    logic [15:0] len_field;
    logic [15:0] sum;
    logic [7:0]  b;
    int          total;
    len_field = 16'(len);
    frame_bytes.push_back(cfg_first);
    frame_bytes.push_back(cfg_second);
    frame_bytes.push_back(len_field[15:8]);
    frame_bytes.push_back(len_field[7:0]);
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = seq[15:8];
      else if (i == 1) b = seq[7:0];
      else if (i == 2) b = cmd;
      else if (fill >= 0) b = 8'(fill);
      else b = 8'($urandom);
      frame_bytes.push_back(b);
    end
    sum = '0;
    foreach (frame_bytes[k]) sum = sum + 16'(frame_bytes[k]);
    if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(15));
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
    total = frame_bytes.size();
    if (cut >= 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) rx_pending.push_back(frame_bytes[i]);
    queued_count += total;
  endtask

  // every verdict but overflow, field extremes and the header resync cases
  task automatic queue_directed();
    queue_frame(3, scfp_pkg::CMD_FORWARD, 16'h0000, 1'b0, -1, -1);   // shortest full frame
    queue_frame(4, scfp_pkg::CMD_SHELL, 16'hFFFF, 1'b0, -1, 8'hFF);
    queue_frame(5, 8'hFF, 16'h8001, 1'b0, -1, 8'h00);                // unknown command
    queue_frame(3, 8'h00, 16'h7FFE, 1'b0, -1, -1);
    queue_frame(6, scfp_pkg::CMD_FORWARD, 16'h1234, 1'b1, -1, -1);   // bad sum
    queue_frame(4, scfp_pkg::CMD_SHELL, 16'hA5A5, 1'b1, -1, -1);
    queue_frame(0, scfp_pkg::CMD_FORWARD, 16'h0000, 1'b0, -1, -1);   // runts
    queue_frame(1, scfp_pkg::CMD_FORWARD, 16'hC300, 1'b0, -1, -1);
    queue_frame(2, scfp_pkg::CMD_FORWARD, 16'h00C3, 1'b1, -1, -1);
    // repeated first header byte, then a first byte followed by junk
    rx_pending.push_back(cfg_first);
    queue_frame(3, scfp_pkg::CMD_SHELL, 16'h0102, 1'b0, -1, -1);
    rx_pending.push_back(cfg_first);
    rx_pending.push_back(idle_byte());
    queue_frame(3, scfp_pkg::CMD_FORWARD, 16'hFEDC, 1'b0, -1, -1);
  endtask

  // mostly well-formed frames, some cut short, some loose noise
  task automatic queue_random(input int budget);
    int         start;
    int         len;
    int         sel;
    logic [7:0] cmd;
    start = queued_count;
    while (queued_count - start < budget) begin
      sel = $urandom_range(9);
      if (sel == 0) len = $urandom_range(2);
      else if (sel < 8) len = $urandom_range(24, 3);
      else len = $urandom_range(300, 25);
      sel = $urandom_range(2);
      if (sel == 0) cmd = scfp_pkg::CMD_FORWARD;
      else if (sel == 1) cmd = scfp_pkg::CMD_SHELL;
      else cmd = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 72) begin
        queue_frame(len, cmd, 16'($urandom), $urandom_range(4) == 0, -1, -1);
      end else if (sel < 86) begin
        // cut after the length so the next frame is only partly swallowed
        queue_frame(len, cmd, 16'($urandom), 1'b0, $urandom_range(len + 5, 4), -1);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(2) == 0) rx_pending.push_back(cfg_first);
          else rx_pending.push_back(8'($urandom));
          queued_count++;
        end
      end
    end
  endtask

  // wait until every byte is sent and every result has come back, then let the pipe empty
  task automatic drain();
    while (rx_pending.size() != 0 || in_valid || expected_body.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // finish any partial frame with junk so register writes land while hunting
  task automatic settle_parser();
    drain();
    while (hunt_state != scfp_pkg::HUNT_FIRST) begin
      repeat (16) rx_pending.push_back(idle_byte());
      drain();
    end
  endtask

  task automatic write_reg(input logic [scfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scfp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      scfp_pkg::REG_HEAD_FIRST:   cfg_first  = data;
      scfp_pkg::REG_HEAD_SECOND:  cfg_second = data;
      scfp_pkg::REG_CHECK_ENABLE: cfg_check  = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // sequencer
  initial begin
    cfg_first  = scfp_pkg::HEAD_FIRST_RESET;
    cfg_second = scfp_pkg::HEAD_SECOND_RESET;
    cfg_check  = 1'b0;
    len_high   = '0;
    seq_num    = '0;
    cmd_byte   = '0;
    sum_high   = '0;
    restart_hunt();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, no idling; pause after the directed frames
    queue_directed();
    drain();
    queue_random(200);
    settle_parser();

    // low/high header extremes, checking on (only bit 0 of the data counts)
    write_reg(scfp_pkg::REG_HEAD_FIRST, 8'h00);
    write_reg(scfp_pkg::REG_HEAD_SECOND, 8'hFF);
    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h03);
    send_idle_pct = 64;
    queue_directed();
    queue_random(220);
    settle_parser();

    // swapped extremes, receiver stalling
    write_reg(scfp_pkg::REG_HEAD_FIRST, 8'hFF);
    write_reg(scfp_pkg::REG_HEAD_SECOND, 8'h00);
    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h01);
    send_idle_pct = 0;
    stall_pct     = 64;
    queue_directed();
    queue_random(220);
    settle_parser();

    // both header bytes equal, checking off via an even value, a write past the list
    write_reg(scfp_pkg::REG_HEAD_FIRST, 8'h3C);
    write_reg(scfp_pkg::REG_HEAD_SECOND, 8'h3C);
    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'hFE);
    write_reg(REG_UNUSED, 8'hFF);
    send_idle_pct = 18;
    stall_pct     = 18;
    queue_random(220);
    settle_parser();

    // default headers back, checking on, largest frames with no idling
    write_reg(scfp_pkg::REG_HEAD_FIRST, scfp_pkg::HEAD_FIRST_RESET);
    write_reg(scfp_pkg::REG_HEAD_SECOND, scfp_pkg::HEAD_SECOND_RESET);
    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h01);
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_frame(MAX_PACKET - scfp_pkg::FRAME_OVERHEAD, scfp_pkg::CMD_FORWARD, 16'hA55A,
                1'b0, -1, -1);
    queue_frame(MAX_PACKET - scfp_pkg::FRAME_OVERHEAD - 1, scfp_pkg::CMD_SHELL, 16'h0FF0,
                1'b1, -1, -1);
    drain();
    // one byte past the limit, and the largest length field, both abort
    queue_frame(MAX_PACKET - scfp_pkg::FRAME_OVERHEAD + 1, scfp_pkg::CMD_SHELL, 16'h3344,
                1'b0, MAX_PACKET, -1);
    queue_frame(16'hFFFF, scfp_pkg::CMD_FORWARD, 16'hFFFF, 1'b0, MAX_PACKET, -1);
    queue_directed();
    queue_random(150);
    settle_parser();

    // checking off again, light idling on both sides
    write_reg(scfp_pkg::REG_CHECK_ENABLE, 8'h00);
    send_idle_pct = 18;
    stall_pct     = 18;
    queue_random(250);
    drain();

    if (mismatches == 0 && expected_body.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
